>>> rtl/core/sllm_pkg.sv
// Shared types, widths and constants of the static linked list manager.
package sllm_pkg;

    localparam int NODES        = 1024;
    localparam int LINK_W       = $clog2(NODES);
    localparam int POS_W        = 10;
    localparam int VAL_W        = 32;
    localparam int CNT_W        = 11;
    localparam int LEN_W        = 10;
    localparam int STAT_W       = 2;
    localparam int IN_TDATA_W   = 48;
    localparam int OUT_TDATA_W  = 16;

    localparam logic [LINK_W-1:0] FREE_HEAD = '0;
    localparam logic [LINK_W-1:0] LIST_HEAD = LINK_W'(NODES - 1);

    typedef enum logic [STAT_W-1:0] {
        ST_DONE   = 2'd0,
        ST_RANGE  = 2'd1,
        ST_NOFREE = 2'd2
    } t_status;

    // read address source for the link memory
    typedef enum logic [1:0] {
        RD_K    = 2'd0,
        RD_FREE = 2'd1,
        RD_DATA = 2'd2
    } t_rd_sel;

    // write address / data pair for the link memory
    typedef enum logic [2:0] {
        WR_NONE      = 3'd0,
        WR_CLEAR     = 3'd1,
        WR_FREE_DATA = 3'd2,
        WR_J_DATA    = 3'd3,
        WR_K_J       = 3'd4,
        WR_K_DATA    = 3'd5,
        WR_FREE_J    = 3'd6
    } t_wr_sel;

    typedef struct packed {
        logic    latch_in;
        logic    init_walk;
        logic    ld_j;
        logic    ld_k;
        logic    dec_steps;
        logic    inc_cnt;
        logic    dec_cnt;
        logic    val_wr;
        logic    set_status;
        logic    out_load;
        t_status status;
        t_rd_sel rd_sel;
        t_wr_sel wr_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic range_bad;
        logic rd_zero;
        logic rd_head;
        logic steps_zero;
        logic op_delete;
        logic cnt_zero;
    } t_dp_stat;

    // link value that the clearing pass writes into a node
    function automatic logic [LINK_W-1:0] init_link(input logic [LINK_W-1:0] idx);
        if (idx < LINK_W'(NODES - 2)) begin
            return idx + LINK_W'(1);
        end
        return FREE_HEAD;
    endfunction

endpackage

>>> rtl/core/sllm_dp.sv
// Datapath: link and value memories, walk registers, element counter, result register.
module sllm_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sllm_pkg::t_dp_cmd                   i_cmd,
    input  logic                                i_op,
    input  logic [sllm_pkg::POS_W-1:0]          i_position,
    input  logic signed [sllm_pkg::VAL_W-1:0]   i_value,
    output sllm_pkg::t_dp_stat                  o_stat,
    output sllm_pkg::t_status                   o_status,
    output logic [sllm_pkg::LEN_W-1:0]          o_length
);
    import sllm_pkg::*;

    localparam int CMP_W = CNT_W + 1;

    logic [LINK_W-1:0]        mem_link [NODES];
    logic signed [VAL_W-1:0]  mem_value [NODES];

    logic [LINK_W-1:0]        r_rdata;
    logic                     r_op;
    logic [POS_W-1:0]         r_pos;
    logic signed [VAL_W-1:0]  r_value;
    logic [LINK_W-1:0]        r_k;
    logic [LINK_W-1:0]        r_j;
    logic [POS_W-1:0]         r_steps;
    logic [CNT_W-1:0]         r_count;
    logic [LINK_W-1:0]        r_clr_idx;
    t_status                  r_res_status;
    t_status                  r_out_status;
    logic [LEN_W-1:0]         r_out_length;

    logic [LINK_W-1:0]        w_rd_link;
    logic [LINK_W-1:0]        w_raddr;
    logic [LINK_W-1:0]        w_waddr;
    logic [LINK_W-1:0]        w_wdata;
    logic                     w_wr_en;
    logic [CMP_W-1:0]         w_pos_ext;
    logic [CMP_W-1:0]         w_cnt_ext;

    // out-of-range link reads as end of chain
    assign w_rd_link = ((LINK_W + 1)'(r_rdata) < (LINK_W + 1)'(NODES)) ? r_rdata : FREE_HEAD;

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_FREE: w_raddr = FREE_HEAD;
            RD_DATA: w_raddr = w_rd_link;
            default: w_raddr = r_k;
        endcase
    end

    always_comb begin
        w_wr_en = 1'b1;
        w_waddr = r_k;
        w_wdata = r_j;
        unique case (i_cmd.wr_sel)
            WR_NONE: begin
                w_wr_en = 1'b0;
            end
            WR_CLEAR: begin
                w_waddr = r_clr_idx;
                w_wdata = init_link(r_clr_idx);
            end
            WR_FREE_DATA: begin
                w_waddr = FREE_HEAD;
                w_wdata = w_rd_link;
            end
            WR_J_DATA: begin
                w_waddr = r_j;
                w_wdata = w_rd_link;
            end
            WR_K_J: begin
                w_waddr = r_k;
                w_wdata = r_j;
            end
            WR_K_DATA: begin
                w_waddr = r_k;
                w_wdata = w_rd_link;
            end
            WR_FREE_J: begin
                w_waddr = FREE_HEAD;
                w_wdata = r_j;
            end
            default: begin
                w_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem_link[w_waddr] <= w_wdata;
        end
        r_rdata <= mem_link[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.val_wr) begin
            mem_value[w_rd_link] <= r_value;
        end
    end

    // payload, walk, status and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_op    <= i_op;
            r_pos   <= i_position;
            r_value <= i_value;
        end
        if (i_cmd.init_walk) begin
            r_k     <= LIST_HEAD;
            r_steps <= r_pos - POS_W'(1);
        end else begin
            if (i_cmd.ld_k) begin
                r_k <= w_rd_link;
            end
            if (i_cmd.dec_steps) begin
                r_steps <= r_steps - POS_W'(1);
            end
        end
        if (i_cmd.ld_j) begin
            r_j <= w_rd_link;
        end
        if (i_cmd.set_status) begin
            r_res_status <= i_cmd.status;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_length <= r_count[LEN_W-1:0];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_clr_idx <= '0;
        end else begin
            if (i_cmd.wr_sel == WR_CLEAR) begin
                r_clr_idx <= r_clr_idx + LINK_W'(1);
            end
            if (i_cmd.inc_cnt) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.dec_cnt) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    assign w_pos_ext = CMP_W'(r_pos);
    assign w_cnt_ext = CMP_W'(r_count);

    always_comb begin
        o_stat.clr_last   = (r_clr_idx == LIST_HEAD);
        o_stat.rd_zero    = (w_rd_link == FREE_HEAD);
        o_stat.rd_head    = (w_rd_link == LIST_HEAD);
        o_stat.steps_zero = (r_steps == '0);
        o_stat.op_delete  = r_op;
        o_stat.cnt_zero   = (r_count == '0);
        if (r_op) begin
            o_stat.range_bad = (r_pos == '0) || (w_pos_ext > w_cnt_ext);
        end else begin
            o_stat.range_bad = (r_pos == '0) || (w_pos_ext > w_cnt_ext + CMP_W'(1));
        end
    end

    assign o_status = r_out_status;
    assign o_length = r_out_length;

endmodule

>>> rtl/core/sllm_ctrl.sv
// Controller: sequences the clearing pass, the walk and the splice of each item.
module sllm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    input  sllm_pkg::t_dp_stat  i_stat,
    output sllm_pkg::t_dp_cmd   o_cmd
);
    import sllm_pkg::*;

    typedef enum logic [12:0] {
        S_CLEAR    = 13'b0000000000001,
        S_IDLE     = 13'b0000000000010,
        S_CHECK    = 13'b0000000000100,
        S_I_FREE   = 13'b0000000001000,
        S_I_POP    = 13'b0000000010000,
        S_WALK     = 13'b0000000100000,
        S_WAIT     = 13'b0000001000000,
        S_LINK     = 13'b0000010000000,
        S_I_SPLICE = 13'b0000100000000,
        S_D_UNLINK = 13'b0001000000000,
        S_D_FREE   = 13'b0010000000000,
        S_D_PUSH   = 13'b0100000000000,
        S_DONE     = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_m_tready;
        o_s_tready  = 1'b0;
        o_cmd       = '0;
        o_cmd.status = ST_DONE;
        o_cmd.rd_sel = RD_K;
        o_cmd.wr_sel = WR_NONE;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.wr_sel = WR_CLEAR;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.init_walk = 1'b1;
                if (i_stat.range_bad) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_RANGE;
                    n_state          = S_DONE;
                end else if (i_stat.op_delete) begin
                    n_state = S_WALK;
                end else begin
                    o_cmd.rd_sel = RD_FREE;
                    n_state      = S_I_FREE;
                end
            end
            S_I_FREE: begin
                if (i_stat.rd_zero) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_NOFREE;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.ld_j   = 1'b1;
                    o_cmd.val_wr = 1'b1;
                    o_cmd.rd_sel = RD_DATA;
                    n_state      = S_I_POP;
                end
            end
            S_I_POP: begin
                o_cmd.wr_sel = WR_FREE_DATA;
                n_state      = S_WALK;
            end
            S_WALK: begin
                o_cmd.rd_sel = RD_K;
                if (i_stat.steps_zero) begin
                    n_state = S_LINK;
                end else begin
                    o_cmd.dec_steps = 1'b1;
                    n_state         = S_WAIT;
                end
            end
            S_WAIT: begin
                o_cmd.ld_k = 1'b1;
                n_state    = S_WALK;
            end
            S_LINK: begin
                if (!i_stat.op_delete) begin
                    o_cmd.wr_sel = WR_J_DATA;
                    n_state      = S_I_SPLICE;
                end else if (i_stat.rd_zero || i_stat.rd_head) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_RANGE;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.ld_j   = 1'b1;
                    o_cmd.rd_sel = RD_DATA;
                    n_state      = S_D_UNLINK;
                end
            end
            S_I_SPLICE: begin
                o_cmd.wr_sel     = WR_K_J;
                o_cmd.inc_cnt    = 1'b1;
                o_cmd.set_status = 1'b1;
                o_cmd.status     = ST_DONE;
                n_state          = S_DONE;
            end
            S_D_UNLINK: begin
                o_cmd.wr_sel = WR_K_DATA;
                o_cmd.rd_sel = RD_FREE;
                n_state      = S_D_FREE;
            end
            S_D_FREE: begin
                o_cmd.wr_sel = WR_J_DATA;
                n_state      = S_D_PUSH;
            end
            S_D_PUSH: begin
                o_cmd.wr_sel     = WR_FREE_J;
                o_cmd.dec_cnt    = 1'b1;
                o_cmd.set_status = 1'b1;
                o_cmd.status     = ST_DONE;
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

>>> rtl/core/static_linked_list_manager_core.sv
// Sequence: an item walks to its position p before its result is offered; a failed range
//   check goes straight to the result, and an insert with no free node stops after the free read.
// Throughput: one item at a time, the next accepted in the cycle after the result is loaded;
//   the walk spends a WALK and a WAIT state on each link, for the registered read port of the link
//   memory, so the position sets the time taken, and a stalled result delays the finish.
// Reset: synchronous, active low; afterwards a clearing pass over every link entry rebuilds the
//   free chain, one link entry a cycle, and no item is accepted until it ends.
// Top level of the static linked list manager: cursor list with a free chain.
module static_linked_list_manager_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave side: insert / delete requests
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata: [9:0] position, [41:10] value, [47:42] zero
    input  logic [sllm_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // tuser: [0] op (0 insert before position, 1 delete at position)
    input  logic [0:0]                          i_s_axis_tuser,
    // master side: results
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // tdata: [1:0] status, [11:2] length, [15:12] zero
    output logic [sllm_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);
    import sllm_pkg::*;

    localparam int OUT_PAD_W = OUT_TDATA_W - LEN_W - STAT_W;

    t_dp_cmd                  w_cmd;
    t_dp_stat                 w_stat;
    t_status                  w_status;
    logic [LEN_W-1:0]         w_length;
    logic [POS_W-1:0]         w_position;
    logic signed [VAL_W-1:0]  w_value;

    // unpack the request item
    assign w_position = i_s_axis_tdata[POS_W-1:0];
    assign w_value    = i_s_axis_tdata[POS_W+VAL_W-1:POS_W];

    // controller: owns the state machine and the result valid flag
    sllm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // datapath: link memory, walk pointers, element counter and result register
    sllm_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_op       (i_s_axis_tuser[0]),
        .i_position (w_position),
        .i_value    (w_value),
        .o_stat     (w_stat),
        .o_status   (w_status),
        .o_length   (w_length)
    );

    // pack the result item, status in the low bits
    assign o_m_axis_tdata = {{OUT_PAD_W{1'b0}}, w_length, w_status};

`ifndef ASSERT_OFF
    // one item in flight: no second accept right after one
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("request accepted while an item is in flight");

    // the clearing pass blocks requests
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.wr_sel == WR_CLEAR) |-> !o_s_axis_tready)
        else $error("request ready during clearing pass");

    // a delete never runs the element count below zero
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.dec_cnt |-> !w_stat.cnt_zero)
        else $error("element count underflow");

    // a splice only follows a successful range check
    a_splice_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.inc_cnt || w_cmd.dec_cnt) |-> !w_stat.range_bad)
        else $error("count changed on an out-of-range item");
`endif

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the static linked list manager core.
`timescale 1ns / 100ps

module testbench;
    import sllm_pkg::*;

    localparam int MAX_ELEMS = NODES - 2;
    // list length built up before the deep and mixed phases
    localparam int FILL_LEN = 64;
    // slowest single item: full-depth walk plus result handoff
    localparam int WALK_CYCLES = 2 * NODES + 64;

    typedef struct {
        logic              is_del;
        logic [POS_W-1:0]  pos;
        logic [VAL_W-1:0]  val;
    } t_list_req;

    typedef struct {
        t_status           st;
        logic [LEN_W-1:0]  len;
    } t_list_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_valid = 1'b0;
    logic [IN_TDATA_W-1:0]   s_data = '0;
    logic [0:0]              s_user = '0;
    logic                    m_ready = 1'b0;
    logic                    s_ready;
    logic                    m_valid;
    logic [OUT_TDATA_W-1:0]  m_data;

    t_list_req     pending_reqs[$];
    t_list_result  awaited_results[$];
    t_list_req     cur_req;

    // shadow of the node links and the element counter
    logic [LINK_W-1:0]  next_link [NODES];
    logic [CNT_W-1:0]   elem_cnt;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int fault_count = 0;
    int plan_len = 0;

    static_linked_list_manager_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Apply one operation to the shadow list and return the status and new length.
    function automatic t_list_result list_predict(input logic is_del, input logic [POS_W-1:0] pos);
        t_list_result r;
        logic [LINK_W-1:0] k;
        logic [LINK_W-1:0] j;
        int s;
        r.st = ST_DONE;
        if (!is_del) begin
            if (pos == 0 || int'(pos) > int'(elem_cnt) + 1) begin
                r.st = ST_RANGE;
            end else begin
                j = next_link[FREE_HEAD];
                if (j == FREE_HEAD) begin
                    r.st = ST_NOFREE;
                end else begin
                    next_link[FREE_HEAD] = next_link[j];
                    k = LIST_HEAD;
                    for (s = 1; s < int'(pos); s++) k = next_link[k];
                    next_link[j] = next_link[k];
                    next_link[k] = j;
                    elem_cnt = elem_cnt + 1'b1;
                end
            end
        end else begin
            if (pos == 0 || int'(pos) > int'(elem_cnt)) begin
                r.st = ST_RANGE;
            end else begin
                k = LIST_HEAD;
                for (s = 1; s < int'(pos); s++) k = next_link[k];
                j = next_link[k];
                if (j != FREE_HEAD && j != LIST_HEAD) begin
                    next_link[k] = next_link[j];
                    next_link[j] = next_link[FREE_HEAD];
                    next_link[FREE_HEAD] = j;
                    elem_cnt = elem_cnt - 1'b1;
                end else begin
                    r.st = ST_RANGE;
                end
            end
        end
        r.len = elem_cnt[LEN_W-1:0];
        return r;
    endfunction

    // Driver: predict each accepted item, then offer the next pending one.
    always @(posedge i_clk) begin : req_feed
        int n;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
            // free chain 1..NODES-2, empty element chain
            for (n = 0; n < NODES; n++) begin
                next_link[n] = (n < NODES - 2) ? LINK_W'(n + 1) : FREE_HEAD;
            end
            elem_cnt = '0;
        end else begin
            if (s_valid && s_ready) begin
                awaited_results.push_back(list_predict(cur_req.is_del, cur_req.pos));
            end
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_req = pending_reqs.pop_front();
                    s_valid <= 1'b1;
                    s_data  <= {{(IN_TDATA_W - VAL_W - POS_W){1'b0}}, cur_req.val, cur_req.pos};
                    s_user  <= cur_req.is_del;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random and compare each result with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_list_result want;
        t_status got_st;
        logic [LEN_W-1:0] got_len;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_valid && m_ready) begin
                got_st  = t_status'(m_data[STAT_W-1:0]);
                got_len = m_data[STAT_W +: LEN_W];
                if (awaited_results.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("unexpected result: status %0d length %0d", got_st, got_len);
                end else begin
                    want = awaited_results.pop_front();
                    if (want.st !== got_st || want.len !== got_len) begin
                        fault_count++;
                        if (fault_count <= 10)
                            $display("result mismatch: expected status %0d length %0d, got %0d %0d",
                                     want.st, want.len, got_st, got_len);
                    end
                end
            end
        end
    end

    // Queue one request and track the length it should leave behind.
    task automatic queue_req(input logic is_del, input int pos, input logic [VAL_W-1:0] val);
        t_list_req q;
        q.is_del = is_del;
        q.pos    = POS_W'(pos);
        q.val    = val;
        pending_reqs.push_back(q);
        if (!is_del) begin
            if (pos >= 1 && pos <= plan_len + 1 && plan_len < MAX_ELEMS) plan_len++;
        end else if (pos >= 1 && pos <= plan_len) begin
            plan_len--;
        end
    endtask

    // Hold until every queued item is taken and every result has come back.
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_valid || awaited_results.size() != 0)
            @(negedge i_clk);
    endtask

    // Mostly shallow positions, some anywhere in range, some pure noise.
    function automatic int pick_pos(input int maxp);
        int r;
        int shallow;
        r = $urandom_range(9);
        if (maxp < 1) maxp = 1;
        shallow = (maxp < 8) ? maxp : 8;
        if (r < 5) return $urandom_range(shallow, 1);
        if (r < 8) return $urandom_range(maxp, 1);
        return $urandom_range(1023, 0);
    endfunction

    initial begin : stimulus
        int n;
        int p;
        logic d;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: range edges, front / middle / back splices, extreme values
        send_idle_pct = 0;
        recv_stall_pct = 0;
        queue_req(1'b1, 1, 32'h0);              // delete on empty list
        queue_req(1'b0, 0, 32'h1234_5678);      // insert at position zero
        queue_req(1'b0, 2, 32'h1);              // insert past length+1
        queue_req(1'b0, 1, 32'h7fff_ffff);
        queue_req(1'b0, 1, 32'h8000_0000);      // insert at front
        queue_req(1'b0, 3, 32'hffff_ffff);      // append at length+1
        queue_req(1'b0, 2, 32'h0);              // insert in the middle
        queue_req(1'b0, 1023, 32'h5555_aaaa);   // all-ones position, out of range
        queue_req(1'b1, 0, 32'h0);
        queue_req(1'b1, 5, 32'h0);              // delete past length
        queue_req(1'b1, 4, 32'hffff_ffff);      // delete last
        queue_req(1'b1, 1, 32'h0);              // delete first
        queue_req(1'b0, 3, 32'haaaa_5555);
        queue_req(1'b1, 2, 32'h0);              // delete middle
        queue_req(1'b1, 1023, $urandom());
        queue_req(1'b0, 512, $urandom());
        queue_req(1'b1, 1, 32'h0);
        queue_req(1'b1, 1, 32'h0);
        queue_req(1'b0, 1, $urandom());         // reuse freed nodes
        wait_drained();

        // build a longer list: shallow splices and deletes, with a few deep appends
        send_idle_pct = 70;
        while (plan_len < FILL_LEN) begin
            if (plan_len > 0 && $urandom_range(9) == 0) begin
                queue_req(1'b1, $urandom_range((plan_len < 8) ? plan_len : 8, 1), $urandom());
            end else if ($urandom_range(39) == 0) begin
                queue_req(1'b0, plan_len + 1, $urandom());
            end else begin
                queue_req(1'b0, $urandom_range((plan_len + 1 < 8) ? plan_len + 1 : 8, 1),
                          $urandom());
            end
        end
        wait_drained();

        // long list: deepest delete and append, range edges at the tail
        send_idle_pct = 28;
        recv_stall_pct = 28;
        queue_req(1'b0, 1, $urandom());
        queue_req(1'b0, 1023, $urandom());
        queue_req(1'b0, plan_len + 2, $urandom());
        queue_req(1'b1, 1023, $urandom());
        queue_req(1'b1, plan_len, $urandom());
        queue_req(1'b0, plan_len + 1, $urandom());
        queue_req(1'b1, plan_len + 1, $urandom());
        queue_req(1'b1, 1, $urandom());
        queue_req(1'b0, 1, $urandom());
        queue_req(1'b0, 0, $urandom());
        wait_drained();

        // mixed traffic, deletes favored so the list shrinks
        send_idle_pct = 0;
        recv_stall_pct = 70;
        for (n = 0; n < 100; n++) begin
            d = ($urandom_range(99) < 60);
            queue_req(d, pick_pos(d ? plan_len : plan_len + 1), $urandom());
        end
        wait_drained();

        // drain to empty with shallow deletes
        send_idle_pct = 28;
        recv_stall_pct = 28;
        while (plan_len > 0)
            queue_req(1'b1, $urandom_range((plan_len < 4) ? plan_len : 4, 1), $urandom());
        wait_drained();

        // short list again, no idling
        send_idle_pct = 0;
        recv_stall_pct = 0;
        queue_req(1'b1, 1, $urandom());
        for (n = 0; n < 30; n++) begin
            d = ($urandom_range(99) < 40);
            p = $urandom_range(plan_len + 2, 0);
            queue_req(d, p, $urandom());
        end
        wait_drained();

        repeat (WALK_CYCLES) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // Watchdog: well beyond the slowest legal run, clearing pass included.
    initial begin : watchdog
        #160_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/sllm_pkg.sv
rtl/core/sllm_dp.sv
rtl/core/sllm_ctrl.sv
rtl/core/static_linked_list_manager_core.sv
tb/testbench.sv
